>>> sv/sle_pkg.sv
// Shared types and constants for the sequential list engine.
`default_nettype none
package sle_pkg;
   localparam int unsigned Depth = 32;
   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned CntW = 6;
   localparam int unsigned DataW = 32;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_DELMIN = 3'd2;
   localparam logic [2:0] ACT_REVERSE = 3'd3;
   localparam logic [2:0] ACT_RANGE = 3'd4;
   localparam logic [2:0] ACT_SORTUP = 3'd5;
   localparam logic [2:0] ACT_SORTDN = 3'd6;
   localparam logic [2:0] ACT_READ = 3'd7;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BADPOS = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [DataW-1:0] wdata;
      logic [AddrW-1:0] raddr;
   } mem_ctl_type;
endpackage
`default_nettype wire

>>> sv/sle_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module sle_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> sv/sle_ctrl.sv
// Command sequencer: walks the element memory with at most one read and one write per cycle.
`default_nettype none
module sle_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_action,
   input  wire logic [5:0]                  req_position,
   input  wire logic signed [31:0]          req_value,
   input  wire logic signed [31:0]          req_limit_high,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic signed [31:0]               rsp_element,
   output logic [5:0]                       rsp_count,
   output sle_pkg::mem_ctl_type             mem_ctl,
   input  wire logic [sle_pkg::DataW-1:0]   mem_rdata
);
   import sle_pkg::*;

   // state codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INS = 4'd1;   // shift tail up, high to low
   localparam logic [3:0] S_DEL = 4'd2;   // shift tail down
   localparam logic [3:0] S_MIN = 4'd3;   // scan for minimum
   localparam logic [3:0] S_MINF = 4'd4;  // move last into min slot
   localparam logic [3:0] S_REVA = 4'd5;  // reverse: read low
   localparam logic [3:0] S_REVB = 4'd6;  // reverse: latch low, read high
   localparam logic [3:0] S_REVC = 4'd7;  // reverse: write low with high data
   localparam logic [3:0] S_RNG = 4'd8;   // compact range
   localparam logic [3:0] S_SRTA = 4'd9;  // sort: read i
   localparam logic [3:0] S_SRTB = 4'd10; // sort: read j, compare
   localparam logic [3:0] S_SRTC = 4'd11; // sort: write i at row end; reverse: write high
   localparam logic [3:0] S_RD = 4'd12;   // read: wait data
   localparam logic [3:0] S_DONE = 4'd13;

   logic [3:0]       state_ff, state_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [2:0]       act_ff, act_in;
   logic [CntW-1:0]  ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic [DataW-1:0] val_ff, val_in, hi_ff, hi_in, hold_ff, hold_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             ov_ff, ov_in;
   logic [2:0]       st_ff, st_in;
   logic [DataW-1:0] el_ff, el_in;
   logic [CntW-1:0]  oc_ff, oc_in;
   logic [CntW-1:0]  pos_m1;
   logic [CntW:0]    last_w;

   assign pos_m1 = req_position - CntW'(1);
   assign last_w = {1'b0, cnt_ff} - 7'd1;
   assign req_stall = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_status = st_ff;
   assign rsp_element = el_ff;
   assign rsp_count = oc_ff;

   // next-state and memory control
   always_comb begin
      logic [DataW-1:0] x;
      x = mem_rdata;
      state_in = state_ff; cnt_in = cnt_ff; act_in = act_ff;
      ia_in = ia_ff; ib_in = ib_ff; ic_in = ic_ff;
      val_in = val_ff; hi_in = hi_ff; hold_in = hold_ff; rd_ok_in = 1'b0;
      ov_in = ov_ff && rsp_stall;
      st_in = st_ff; el_in = el_ff; oc_in = oc_ff;
      mem_ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !ov_ff) begin
               act_in = req_action; val_in = req_value; hi_in = req_limit_high;
               st_in = ST_OK; el_in = '0;
               state_in = S_DONE;
               unique case (req_action)
                  ACT_INSERT: begin
                     if (req_position == '0 || req_position > cnt_ff + CntW'(1))
                        st_in = ST_BADPOS;
                     else if (cnt_ff >= CntW'(Depth)) st_in = ST_FULL;
                     else begin
                        // ia = dest index, walking down to pos-1
                        ia_in = cnt_ff; ib_in = pos_m1;
                        mem_ctl.raddr = AddrW'(cnt_ff - CntW'(1));
                        rd_ok_in = 1'b1;
                        state_in = S_INS;
                     end
                  end
                  ACT_DELETE, ACT_READ: begin
                     if (req_position == '0 || req_position > cnt_ff) st_in = ST_BADPOS;
                     else begin
                        mem_ctl.raddr = AddrW'(pos_m1);
                        ia_in = pos_m1; rd_ok_in = 1'b1;
                        state_in = (req_action == ACT_READ) ? S_RD : S_DEL;
                     end
                  end
                  ACT_DELMIN: begin
                     if (cnt_ff == '0) st_in = ST_EMPTY;
                     else begin
                        mem_ctl.raddr = '0; ia_in = '0; ib_in = '0; rd_ok_in = 1'b0;
                        state_in = S_MIN;
                     end
                  end
                  ACT_RANGE: begin
                     if (cnt_ff == '0) st_in = ST_EMPTY;
                     else if ($signed(req_value) >= $signed(req_limit_high)) st_in = ST_RANGE;
                     else begin
                        mem_ctl.raddr = '0; ia_in = '0; ib_in = '0;
                        state_in = S_RNG;
                     end
                  end
                  ACT_REVERSE: begin
                     if (cnt_ff >= CntW'(2)) begin
                        ia_in = '0; ib_in = CntW'(last_w); state_in = S_REVA;
                     end
                  end
                  default: begin // sorts
                     if (cnt_ff >= CntW'(2)) begin
                        ia_in = '0; state_in = S_SRTA;
                     end
                  end
               endcase
            end
         end
         S_INS: begin
            // rdata = elem[ia-1]; write to ia
            if (ia_ff == ib_ff) begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = val_ff;
               cnt_in = cnt_ff + CntW'(1); state_in = S_DONE;
            end else begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = x;
               ia_in = ia_ff - CntW'(1);
               mem_ctl.raddr = AddrW'(ia_ff - CntW'(2));
            end
         end
         S_DEL: begin
            // first cycle: rdata is removed element; later: elem[ia+1]
            if (rd_ok_ff) el_in = x;
            else begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = x;
               ia_in = ia_ff + CntW'(1);
            end
            if (CntW'(ia_ff + CntW'(1)) >= cnt_ff && !rd_ok_ff) begin
               cnt_in = cnt_ff - CntW'(1); state_in = S_DONE;
            end else if (rd_ok_ff && ia_ff + CntW'(1) >= cnt_ff) begin
               cnt_in = cnt_ff - CntW'(1); state_in = S_DONE;
            end else begin
               mem_ctl.raddr = AddrW'(rd_ok_ff ? ia_ff + CntW'(1) : ia_ff + CntW'(2));
            end
         end
         S_MIN: begin
            // ib = index whose data arrives now, ia = min index, hold = min
            if (ib_ff == '0 || $signed(x) < $signed(hold_ff)) begin
               hold_in = x; ia_in = ib_ff;
            end
            if (ib_ff + CntW'(1) >= cnt_ff) begin
               mem_ctl.raddr = AddrW'(last_w); state_in = S_MINF;
            end else begin
               ib_in = ib_ff + CntW'(1); mem_ctl.raddr = AddrW'(ib_ff + CntW'(1));
            end
         end
         S_MINF: begin
            el_in = hold_ff;
            mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = x;
            cnt_in = cnt_ff - CntW'(1); state_in = S_DONE;
         end
         S_REVA: begin
            mem_ctl.raddr = AddrW'(ia_ff); state_in = S_REVB;
         end
         S_REVB: begin
            hold_in = x; mem_ctl.raddr = AddrW'(ib_ff); state_in = S_REVC;
         end
         S_REVC: begin
            // write low with high data now, high with held low next
            mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = x;
            hi_in = hold_ff; state_in = S_SRTC; ic_in = '1;
         end
         S_RNG: begin
            // ib = read index of arriving data, ia = write index
            if ($signed(x) <= $signed(val_ff) || $signed(x) >= $signed(hi_ff)) begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = x;
               ia_in = ia_ff + CntW'(1);
            end
            if (ib_ff + CntW'(1) >= cnt_ff) begin
               cnt_in = ia_in; state_in = S_DONE;
            end else begin
               ib_in = ib_ff + CntW'(1); mem_ctl.raddr = AddrW'(ib_ff + CntW'(1));
            end
         end
         S_SRTA: begin
            mem_ctl.raddr = AddrW'(ia_ff); ib_in = ia_ff + CntW'(1);
            state_in = S_SRTB; rd_ok_in = 1'b1;
         end
         S_SRTB: begin
            // first cycle latches elem[i]; then compare with arriving elem[j]
            if (rd_ok_ff) begin
               hold_in = x; mem_ctl.raddr = AddrW'(ib_ff);
            end else begin
               if ($signed(hold_ff) > $signed(x)) begin
                  // elem[j] <= hold, hold <= x for slot i
                  mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ib_ff); mem_ctl.wdata = hold_ff;
                  hold_in = x;
               end
               if (ib_ff + CntW'(1) >= cnt_ff) begin
                  hi_in = hold_in; ic_in = '0; state_in = S_SRTC;
               end else begin
                  ib_in = ib_ff + CntW'(1); mem_ctl.raddr = AddrW'(ib_ff + CntW'(1));
               end
            end
         end
         S_SRTC: begin
            // write back held value; shared by sort row end and reverse
            if (ic_ff == '1) begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ib_ff); mem_ctl.wdata = hi_ff;
               ia_in = ia_ff + CntW'(1); ib_in = ib_ff - CntW'(1);
               state_in = (ia_ff + CntW'(1) < ib_ff - CntW'(1)) ? S_REVA : S_DONE;
            end else begin
               mem_ctl.we = 1'b1; mem_ctl.waddr = AddrW'(ia_ff); mem_ctl.wdata = hi_ff;
               ia_in = ia_ff + CntW'(1);
               if (ia_ff + CntW'(2) < cnt_ff) state_in = S_SRTA;
               else if (act_ff == ACT_SORTDN) begin
                  ia_in = '0; ib_in = CntW'(last_w); state_in = S_REVA;
               end else state_in = S_DONE;
            end
         end
         S_RD: begin
            el_in = x; state_in = S_DONE;
         end
         S_DONE: begin
            oc_in = cnt_ff; ov_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; ov_ff <= 1'b0; rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ov_ff <= ov_in; rd_ok_ff <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; ia_ff <= ia_in; ib_ff <= ib_in; ic_ff <= ic_in;
      val_ff <= val_in; hi_ff <= hi_in; hold_ff <= hold_in;
      st_ff <= st_in; el_ff <= el_in; oc_ff <= oc_in;
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth)) else $error("count above depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepting while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_ins: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !req_stall) |=> state_ff != S_IDLE)
      else $error("command lost");
`endif
endmodule
`default_nettype wire

>>> sv/sequential_list_engine.sv
// Top level of the sequential list engine: sequencer plus element memory.
//
// Usage: commands enter on the req_ channel (valid/stall), one result per
// command leaves on the rsp_ channel with status, element and new count.
// One command is worked at a time; req_stall stays high while a command is
// in progress or a result waits. A descending sort is an ascending sort
// followed by a reverse pass. The single read and single write port of the
// element memory set the pace of each command. A result is held steady while
// rsp_stall is high; a new command is taken once it has been delivered.
// Reset (synchronous, active high) empties the list; memory contents are
// not cleared, and stale entries are never used.
`default_nettype none
module sequential_list_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_action,
   input  wire logic [5:0]         req_position,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_limit_high,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_element,
   output logic [5:0]              rsp_count
);
   import sle_pkg::*;

   mem_ctl_type      mem_ctl;
   logic [DataW-1:0] mem_rdata;

   sle_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_position,
      .req_value, .req_limit_high, .rsp_valid, .rsp_stall, .rsp_status,
      .rsp_element, .rsp_count, .mem_ctl, .mem_rdata
   );

   sle_ram #(.Width(DataW), .Depth(Depth)) u_ram (
      .clock, .we(mem_ctl.we), .waddr(mem_ctl.waddr), .wdata(mem_ctl.wdata),
      .raddr(mem_ctl.raddr), .rdata(mem_rdata)
   );
endmodule
`default_nettype wire
